FILE: sv/line_and_box_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// line_and_box_rasterizer_assert.svh
// assertion macros shared by the rasterizer checkers
// ----------------------------------------------------------------------------
`ifndef LINE_AND_BOX_RASTERIZER_ASSERT_SVH
`define LINE_AND_BOX_RASTERIZER_ASSERT_SVH

// condition holds at every edge outside reset
`define LBR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define LBR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// types and constants of the line and box rasterizer
// ----------------------------------------------------------------------------
package lbr_pkg;

  // coordinate widths
  localparam int X_BITS    = 9;
  localparam int Y_BITS    = 8;
  localparam int POS_W     = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int ERR_W     = POS_W + 2;
  localparam int ADDR_W    = 32;
  localparam int COLOR_W   = 16;
  localparam int ROW_SHIFT = 10;
  localparam int CMD_W     = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LINE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BOX  = 2'd2;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [X_BITS-1:0]  x_a;
    logic [Y_BITS-1:0]  y_a;
    logic [X_BITS-1:0]  x_b;
    logic [Y_BITS-1:0]  y_b;
    logic [COLOR_W-1:0] pen_color;
  } in_word_t;

  // result word
  typedef struct packed {
    logic               pixel_valid;
    logic [X_BITS-1:0]  pixel_x;
    logic [Y_BITS-1:0]  pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
    logic               busy_res;
  } out_word_t;

endpackage

FILE: sv/line_and_box_rasterizer.sv
// ----------------------------------------------------------------------------
// line_and_box_rasterizer
// Bresenham line and filled box rasterizer with frame address generation
// ----------------------------------------------------------------------------
// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall  | command, endpoints, color
// out     | output    | out_valid/out_stall| pixel, address, flags
// cfg     | input     | cfg_wr_en          | frame base address
//
// one word in per cycle unless in_stall, one registered result word per word in
// the throughput is set by the combinational error step and the 32-bit address add
// a two-entry output stage (result register plus skid) keeps input flowing
// while the result side stalls; in_stall rises only when both are full
// rst_n is synchronous and clears the shape, the output stage and frame_base
// ----------------------------------------------------------------------------
module line_and_box_rasterizer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [lbr_pkg::ADDR_W-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  lbr_pkg::in_word_t       in_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output lbr_pkg::out_word_t      out_word
);

  localparam int XW = lbr_pkg::X_BITS;
  localparam int YW = lbr_pkg::Y_BITS;
  localparam int PW = lbr_pkg::POS_W;
  localparam int EW = lbr_pkg::ERR_W;
  localparam int AW = lbr_pkg::ADDR_W;
  localparam int CW = lbr_pkg::COLOR_W;

  // configuration
  logic [AW-1:0] frame_base_r;

  // shape state
  logic          drawing_active_r, drawing_active_nxt;
  logic          box_mode_r, box_mode_nxt;
  logic          steep_swap_r, steep_swap_nxt;
  logic [PW-1:0] major_pos_r, major_pos_nxt;
  logic [PW-1:0] major_end_r, major_end_nxt;
  logic [PW-1:0] minor_pos_r, minor_pos_nxt;
  logic signed [EW-1:0] step_error_r, step_error_nxt;
  logic [PW-1:0] major_delta_r, major_delta_nxt;
  logic [PW-1:0] minor_delta_r, minor_delta_nxt;
  logic          minor_down_r, minor_down_nxt;
  logic [CW-1:0] held_color_r, held_color_nxt;
  logic [XW-1:0] box_column_r, box_column_nxt;
  logic [XW-1:0] box_column_end_r, box_column_end_nxt;
  logic [YW-1:0] box_row_start_r, box_row_start_nxt;
  logic [YW-1:0] box_row_end_r, box_row_end_nxt;

  // output stage
  logic               out_valid_r, out_valid_nxt;
  lbr_pkg::out_word_t out_word_r, out_word_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  lbr_pkg::out_word_t skid_word_r, skid_word_nxt;

  // working signals
  logic               in_take;
  logic               out_take;
  lbr_pkg::out_word_t res;
  logic [XW-1:0]      dx;
  logic [YW-1:0]      dy;
  logic               steep;
  logic [PW-1:0]      ma, mb, na, nb;
  logic [PW-1:0]      line_delta;
  logic [XW-1:0]      col_lo, col_hi;
  logic [YW-1:0]      row_lo, row_hi;
  logic signed [EW-1:0] err_sum;
  logic [PW-1:0]      major_inc;
  logic [XW-1:0]      column_inc;
  logic [XW-1:0]      px;
  logic [YW-1:0]      py;
  logic               last;

  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid & ~skid_valid_r;
  assign out_take  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // line setup: axis swap and ordering of endpoints
  always_comb begin
    dx = (in_word.x_a > in_word.x_b) ? in_word.x_a - in_word.x_b
                                     : in_word.x_b - in_word.x_a;
    dy = (in_word.y_a > in_word.y_b) ? in_word.y_a - in_word.y_b
                                     : in_word.y_b - in_word.y_a;
    steep = PW'(dy) > PW'(dx);
    if (steep) begin
      ma = PW'(in_word.y_a);
      mb = PW'(in_word.y_b);
      na = PW'(in_word.x_a);
      nb = PW'(in_word.x_b);
    end else begin
      ma = PW'(in_word.x_a);
      mb = PW'(in_word.x_b);
      na = PW'(in_word.y_a);
      nb = PW'(in_word.y_b);
    end
    if (ma > mb) begin
      {ma, mb} = {mb, ma};
      {na, nb} = {nb, na};
    end
    line_delta = mb - ma;
  end

  // box setup: corner ordering
  always_comb begin
    col_lo = (in_word.x_a < in_word.x_b) ? in_word.x_a : in_word.x_b;
    col_hi = (in_word.x_a < in_word.x_b) ? in_word.x_b : in_word.x_a;
    row_lo = (in_word.y_a < in_word.y_b) ? in_word.y_a : in_word.y_b;
    row_hi = (in_word.y_a < in_word.y_b) ? in_word.y_b : in_word.y_a;
  end

  // one step of the shape and the result word
  always_comb begin
    drawing_active_nxt = drawing_active_r;
    box_mode_nxt       = box_mode_r;
    steep_swap_nxt     = steep_swap_r;
    major_pos_nxt      = major_pos_r;
    major_end_nxt      = major_end_r;
    minor_pos_nxt      = minor_pos_r;
    step_error_nxt     = step_error_r;
    major_delta_nxt    = major_delta_r;
    minor_delta_nxt    = minor_delta_r;
    minor_down_nxt     = minor_down_r;
    held_color_nxt     = held_color_r;
    box_column_nxt     = box_column_r;
    box_column_end_nxt = box_column_end_r;
    box_row_start_nxt  = box_row_start_r;
    box_row_end_nxt    = box_row_end_r;
    res                = '0;
    px                 = '0;
    py                 = '0;
    last               = 1'b0;
    err_sum            = step_error_r + $signed({2'b00, minor_delta_r});
    major_inc          = major_pos_r + PW'(1);
    column_inc         = box_column_r + XW'(1);

    case (in_word.command)
      lbr_pkg::CMD_LINE: begin
        held_color_nxt     = in_word.pen_color;
        steep_swap_nxt     = steep;
        major_pos_nxt      = ma;
        major_end_nxt      = mb;
        minor_pos_nxt      = na;
        major_delta_nxt    = line_delta;
        minor_delta_nxt    = (na > nb) ? na - nb : nb - na;
        minor_down_nxt     = !(na < nb);
        step_error_nxt     = -$signed({2'b00, line_delta >> 1});
        box_mode_nxt       = 1'b0;
        drawing_active_nxt = line_delta != '0;
        res.busy_res       = drawing_active_nxt;
      end
      lbr_pkg::CMD_BOX: begin
        held_color_nxt     = in_word.pen_color;
        box_column_nxt     = col_lo;
        box_column_end_nxt = col_hi;
        box_row_start_nxt  = row_lo;
        box_row_end_nxt    = row_hi;
        major_pos_nxt      = PW'(row_lo);
        box_mode_nxt       = 1'b1;
        drawing_active_nxt = (col_lo < col_hi) && (row_lo < row_hi);
        res.busy_res       = drawing_active_nxt;
      end
      default: begin
        // tick, and the unused code that acts as one
        if (drawing_active_r) begin
          if (box_mode_r) begin
            px            = box_column_r;
            py            = major_pos_r[YW-1:0];
            major_pos_nxt = major_inc;
            if (major_inc >= PW'(box_row_end_r)) begin
              major_pos_nxt  = PW'(box_row_start_r);
              box_column_nxt = column_inc;
              if (column_inc >= box_column_end_r) begin
                last               = 1'b1;
                drawing_active_nxt = 1'b0;
              end
            end
          end else begin
            if (steep_swap_r) begin
              px = minor_pos_r[XW-1:0];
              py = major_pos_r[YW-1:0];
            end else begin
              px = major_pos_r[XW-1:0];
              py = minor_pos_r[YW-1:0];
            end
            // bresenham error step
            step_error_nxt = err_sum;
            if (err_sum >= 0) begin
              minor_pos_nxt  = minor_down_r ? minor_pos_r - PW'(1) : minor_pos_r + PW'(1);
              step_error_nxt = err_sum - $signed({2'b00, major_delta_r});
            end
            major_pos_nxt = major_inc;
            if (major_inc >= major_end_r) begin
              last               = 1'b1;
              drawing_active_nxt = 1'b0;
            end
          end
          res.pixel_valid   = 1'b1;
          res.pixel_x       = px;
          res.pixel_y       = py;
          res.pixel_address = frame_base_r + (AW'(py) << lbr_pkg::ROW_SHIFT)
                              + (AW'(px) << 1);
          res.pixel_color   = held_color_r;
          res.last_pixel    = last;
          res.busy_res      = drawing_active_nxt;
        end
      end
    endcase
  end

  // output register and skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_take;
        out_word_nxt  = res;
      end
    end else if (in_take) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = res;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r     <= '0;
      drawing_active_r <= 1'b0;
      box_mode_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_base_r <= cfg_wr_data;
      end
      if (in_take) begin
        drawing_active_r <= drawing_active_nxt;
        box_mode_r       <= box_mode_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // shape payload and result words
  always_ff @(posedge clk) begin
    if (in_take) begin
      steep_swap_r     <= steep_swap_nxt;
      major_pos_r      <= major_pos_nxt;
      major_end_r      <= major_end_nxt;
      minor_pos_r      <= minor_pos_nxt;
      step_error_r     <= step_error_nxt;
      major_delta_r    <= major_delta_nxt;
      minor_delta_r    <= minor_delta_nxt;
      minor_down_r     <= minor_down_nxt;
      held_color_r     <= held_color_nxt;
      box_column_r     <= box_column_nxt;
      box_column_end_r <= box_column_end_nxt;
      box_row_start_r  <= box_row_start_nxt;
      box_row_end_r    <= box_row_end_nxt;
    end
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

endmodule

FILE: sv/lbr_checker.sv
// ----------------------------------------------------------------------------
// lbr_checker
// port-level checks of the rasterizer result channel
// ----------------------------------------------------------------------------
`include "line_and_box_rasterizer_assert.svh"

module lbr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input lbr_pkg::out_word_t out_word
);

  // classes of word seen on the result port
  logic out_held;
  logic pix_word;
  logic blank_word;
  logic blank_zero;
  logic last_flag;
  logic busy_flag;

  assign out_held   = out_valid && out_stall;
  assign pix_word   = out_valid && out_word.pixel_valid;
  assign blank_word = out_valid && !out_word.pixel_valid;
  assign blank_zero = (out_word.pixel_x == '0) && (out_word.pixel_y == '0) &&
                      (out_word.pixel_address == '0) && (out_word.pixel_color == '0);
  assign last_flag  = out_word.last_pixel;
  assign busy_flag  = out_word.busy_res;

  // a stalled word stays valid and unchanged
  `LBR_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "held word changed")

  // a word with no pixel carries zero position, address and color
  `LBR_ASSERT_ALWAYS(a_empty_zero, !blank_word || blank_zero, "fields set without a pixel")

  // a pixel is either the last one or more follow
  `LBR_ASSERT_ALWAYS(a_last_busy, !pix_word || (last_flag != busy_flag), "last and busy clash")

  // last_pixel only comes with a pixel
  `LBR_ASSERT_ALWAYS(a_last_pix, !blank_word || !last_flag, "last without a pixel")

endmodule

bind line_and_box_rasterizer lbr_checker u_lbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the line and box rasterizer
// ----------------------------------------------------------------------------
// Drives command words through the valid/stall input channel and checks every
// result word against a cycle-free model of the Bresenham line walker and the
// box filler kept inside the bench. Both channels idle at random, the result
// side holds off for a long stretch once, and the frame base is rewritten
// between phases, including values that make the address wrap.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int XB  = lbr_pkg::X_BITS;
  localparam int YB  = lbr_pkg::Y_BITS;
  localparam int AW  = lbr_pkg::ADDR_W;
  localparam int CLW = lbr_pkg::COLOR_W;
  localparam int CMW = lbr_pkg::CMD_W;

  // command code with no meaning of its own, the block treats it as a tick
  localparam logic [CMW-1:0] CMD_UNUSED = 2'd3;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [AW-1:0]      cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  lbr_pkg::in_word_t  in_word     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  lbr_pkg::out_word_t out_word;

  line_and_box_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  always #10 clk = ~clk;

  // shape walker state
  logic          drawing    = 1'b0;
  logic          box_mode   = 1'b0;
  logic          steep      = 1'b0;
  logic          minor_down = 1'b0;
  int            major_pos  = 0;
  int            major_end  = 0;
  int            minor_pos  = 0;
  int            major_len  = 0;
  int            minor_len  = 0;
  int            col        = 0;
  int            col_end    = 0;
  int            row_start  = 0;
  int            row_end    = 0;
  int            step_err   = 0;
  logic [CLW-1:0] pen       = '0;
  logic [AW-1:0] frame_base_q = '0;

  // expected result words, oldest first
  lbr_pkg::out_word_t pixel_q[$];

  int gap_pct    = 18;
  int stall_pct  = 18;
  int hold_left  = 0;
  int err_count  = 0;
  int words_sent = 0;
  int lines_started = 0;
  int boxes_started = 0;
  int pixels_checked = 0;
  int base_writes = 0;

  // next result of the rasterizer for one accepted word
  function automatic lbr_pkg::out_word_t raster_step(input lbr_pkg::in_word_t w);
    lbr_pkg::out_word_t r;
    int xa, ya, xb, yb, ma, mb, na, nb, t, px, py;
    logic last;
    r    = '0;
    last = 1'b0;
    px   = 0;
    py   = 0;
    xa   = int'(w.x_a);
    ya   = int'(w.y_a);
    xb   = int'(w.x_b);
    yb   = int'(w.y_b);
    if (w.command == lbr_pkg::CMD_LINE || w.command == lbr_pkg::CMD_BOX) begin
      pen = w.pen_color;
      if (w.command == lbr_pkg::CMD_LINE) begin
        lines_started++;
        ma = (xa > xb) ? xa - xb : xb - xa;
        na = (ya > yb) ? ya - yb : yb - ya;
        steep = (na > ma);
        if (steep) begin
          ma = ya; mb = yb; na = xa; nb = xb;
        end else begin
          ma = xa; mb = xb; na = ya; nb = yb;
        end
        // walk from the smaller major coordinate
        if (ma > mb) begin
          t = ma; ma = mb; mb = t;
          t = na; na = nb; nb = t;
        end
        major_pos  = ma;
        major_end  = mb;
        minor_pos  = na;
        major_len  = mb - ma;
        minor_len  = (na > nb) ? na - nb : nb - na;
        minor_down = !(na < nb);
        step_err   = -(major_len / 2);
        box_mode   = 1'b0;
        drawing    = (major_len != 0);
      end else begin
        boxes_started++;
        col       = (xa < xb) ? xa : xb;
        col_end   = (xa < xb) ? xb : xa;
        row_start = (ya < yb) ? ya : yb;
        row_end   = (ya < yb) ? yb : ya;
        major_pos = row_start;
        box_mode  = 1'b1;
        drawing   = (col < col_end) && (row_start < row_end);
      end
      r.busy_res = drawing;
      return r;
    end
    if (!drawing) return r;
    if (box_mode) begin
      // column by column, rows from the top down
      px = col;
      py = major_pos;
      major_pos = major_pos + 1;
      if (major_pos >= row_end) begin
        major_pos = row_start;
        col = col + 1;
        if (col >= col_end) begin
          last = 1'b1;
          drawing = 1'b0;
        end
      end
    end else begin
      px = steep ? minor_pos : major_pos;
      py = steep ? major_pos : minor_pos;
      step_err = step_err + minor_len;
      if (step_err >= 0) begin
        minor_pos = minor_down ? minor_pos - 1 : minor_pos + 1;
        step_err = step_err - major_len;
      end
      major_pos = major_pos + 1;
      if (major_pos >= major_end) begin
        last = 1'b1;
        drawing = 1'b0;
      end
    end
    r.pixel_valid   = 1'b1;
    r.pixel_x       = XB'(px);
    r.pixel_y       = YB'(py);
    r.pixel_address = frame_base_q + (AW'(r.pixel_y) << lbr_pkg::ROW_SHIFT)
                      + (AW'(r.pixel_x) << 1);
    r.pixel_color   = pen;
    r.last_pixel    = last;
    r.busy_res      = drawing;
    return r;
  endfunction

  function automatic lbr_pkg::in_word_t make_word(input logic [CMW-1:0] cmd, input int xa,
                                                  input int ya, input int xb, input int yb,
                                                  input int color);
    lbr_pkg::in_word_t w;
    w.command   = cmd;
    w.x_a       = XB'(xa);
    w.y_a       = YB'(ya);
    w.x_b       = XB'(xb);
    w.y_b       = YB'(yb);
    w.pen_color = CLW'(color);
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // one word into the block, with random idle cycles ahead of it
  task automatic send_word(input lbr_pkg::in_word_t w);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pixel_q.push_back(raster_step(w));
    words_sent++;
  endtask

  // tick words carry random payload that the block ignores
  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_word(make_word(($urandom_range(19) == 0) ? CMD_UNUSED : lbr_pkg::CMD_TICK,
                          $urandom_range(511), $urandom_range(255),
                          $urandom_range(511), $urandom_range(255), $urandom));
  endtask

  // stop sending and wait for every expected result word
  task automatic drain;
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_frame_base(input logic [AW-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    frame_base_q = value;
    base_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    lbr_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("result word %0h with nothing expected", out_word));
      end else begin
        want = pixel_q.pop_front();
        pixels_checked += int'(want.pixel_valid);
        check_field("pixel_valid", 32'(out_word.pixel_valid), 32'(want.pixel_valid));
        check_field("pixel_x", 32'(out_word.pixel_x), 32'(want.pixel_x));
        check_field("pixel_y", 32'(out_word.pixel_y), 32'(want.pixel_y));
        check_field("pixel_address", out_word.pixel_address, want.pixel_address);
        check_field("pixel_color", 32'(out_word.pixel_color), 32'(want.pixel_color));
        check_field("last_pixel", 32'(out_word.last_pixel), 32'(want.last_pixel));
        check_field("busy_res", 32'(out_word.busy_res), 32'(want.busy_res));
      end
    end
  end

  // ticks with nothing loaded, including the unused command
  task automatic test_idle_and_unused;
    send_word(make_word(lbr_pkg::CMD_TICK, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_UNUSED, 511, 255, 511, 255, 'hffff));
  endtask

  // shapes that have no pixels at all
  task automatic test_empty_shapes;
    send_word(make_word(lbr_pkg::CMD_LINE, 0, 0, 0, 0, 'h1234));
    send_word(make_word(lbr_pkg::CMD_BOX, 200, 10, 200, 90, 'h5678));
    send_word(make_word(lbr_pkg::CMD_BOX, 10, 255, 300, 255, 'h9abc));
  endtask

  // corner lines, a minor axis walking down, an abort and a small box
  task automatic test_directed_shapes;
    send_word(make_word(lbr_pkg::CMD_LINE, 511, 255, 507, 254, 'hffff));
    send_ticks(4);
    send_word(make_word(lbr_pkg::CMD_LINE, 3, 0, 0, 2, 'h0001));
    send_ticks(3);
    // steep line cut short by a new box
    send_word(make_word(lbr_pkg::CMD_LINE, 0, 0, 1, 5, 'h0000));
    send_ticks(3);
    send_word(make_word(lbr_pkg::CMD_BOX, 511, 255, 509, 253, 'haaaa));
    send_ticks(5);
  endtask

  // hold the result side so the block fills and stalls its input
  task automatic test_output_holdoff;
    gap_pct = 0;
    hold_left = 80;
    send_word(make_word(lbr_pkg::CMD_BOX, 100, 40, 104, 44, 'h7e0f));
    send_ticks(20);
    drain();
    gap_pct = 18;
  endtask

  // mostly well-formed shapes with their ticks, some noise and early aborts
  task automatic test_random_shapes(input int n);
    int kind, xa, ya, xb, yb, npix, nticks, dx, dy;
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      kind = $urandom_range(99);
      xa = $urandom_range(511);
      ya = $urandom_range(255);
      if (kind < 10) begin
        send_word(make_word(CMW'($urandom_range(3)), xa, ya, $urandom_range(511),
                            $urandom_range(255), $urandom));
        continue;
      end
      if (kind < 60 && $urandom_range(39) == 0) begin
        xb = $urandom_range(511);
        yb = $urandom_range(255);
      end else begin
        xb = xa + int'($urandom_range(24)) - 12;
        yb = ya + int'($urandom_range(24)) - 12;
        if (kind >= 60) begin
          xb = xa + int'($urandom_range(12)) - 6;
          yb = ya + int'($urandom_range(12)) - 6;
        end
        xb = (xb < 0) ? 0 : (xb > 511) ? 511 : xb;
        yb = (yb < 0) ? 0 : (yb > 255) ? 255 : yb;
      end
      dx = (xa > xb) ? xa - xb : xb - xa;
      dy = (ya > yb) ? ya - yb : yb - ya;
      if (kind < 60) begin
        send_word(make_word(lbr_pkg::CMD_LINE, xa, ya, xb, yb, $urandom));
        npix = (dy > dx) ? dy : dx;
      end else begin
        send_word(make_word(lbr_pkg::CMD_BOX, xa, ya, xb, yb, $urandom));
        npix = dx * dy;
      end
      nticks = npix + int'($urandom_range(4)) - 2;
      send_ticks((nticks < 0) ? 0 : nticks);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_and_unused();
    test_empty_shapes();
    write_frame_base(32'hffff_f000);
    test_directed_shapes();
    write_frame_base(32'h0000_0000);
    test_output_holdoff();
    write_frame_base($urandom);
    test_random_shapes(400);
    write_frame_base(32'hffff_ffff);
    test_random_shapes(300);
    // a stretch with no idling on either side
    write_frame_base(32'h8000_0000);
    gap_pct = 0;
    stall_pct = 0;
    test_random_shapes(300);
    drain();
    repeat (10) @(posedge clk);

    $display("ran %0d words: %0d line and %0d box starts, %0d pixels checked",
             words_sent, lines_started, boxes_started, pixels_checked);
    $display("frame base rewritten %0d times, incl. all-ones and wrapping bases",
             base_writes);
    if (err_count == 0) begin
      $display("[line_and_box_rasterizer] OK");
    end else begin
      $display("[line_and_box_rasterizer] ERROR");
    end
    $finish;
  end

  // overall run limit
  initial begin
    #5ms;
    $display("run limit reached with %0d words still expected", pixel_q.size());
    $display("[line_and_box_rasterizer] ERROR");
    $finish;
  end

endmodule
